FILE: hdl/fsr_pkg.sv
package fsr_pkg;

    localparam int SLOT_COUNT = 4;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int POS_W      = IDX_W + 1;
    localparam int POS_MOD    = 2 * SLOT_COUNT;

    localparam int BYTES_W = 24;
    localparam int DIM_W   = 12;
    localparam int TIME_W  = 64;
    localparam int MODE_W  = 2;
    localparam int STAT_W  = 2;
    localparam int SLOT_W  = 2;
    localparam int SKIP_W  = 2;
    localparam int DROP_W  = 32;
    localparam int TRIG_W  = 3;
    localparam int CMP_W   = 8;

    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_SLOT_CAPACITY = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CLAMP_TRIGGER = 8'd1;

    localparam logic [BYTES_W-1:0] SLOT_CAPACITY_RST = 24'd3110400;
    localparam logic [TRIG_W-1:0]  CLAMP_TRIGGER_RST = 3'd2;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    localparam logic [MODE_W-1:0] MODE_OLDEST = 2'd0;
    localparam logic [MODE_W-1:0] MODE_CLAMP  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_NEWEST = 2'd2;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_LARGE = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

    typedef logic [POS_W-1:0] pos_t;
    typedef logic [IDX_W-1:0] idx_t;

    typedef struct packed {
        logic               kind;
        logic [BYTES_W-1:0] in_bytes;
        logic [DIM_W-1:0]   in_width;
        logic [DIM_W-1:0]   in_height;
        logic [TIME_W-1:0]  in_time;
        logic [MODE_W-1:0]  read_mode;
        logic [BYTES_W-1:0] buffer_limit;
    } fsr_item_t;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOT_W-1:0]  slot;
        logic [BYTES_W-1:0] out_bytes;
        logic [DIM_W-1:0]   out_width;
        logic [DIM_W-1:0]   out_height;
        logic [TIME_W-1:0]  out_time;
        logic [SKIP_W-1:0]  skipped_frames;
        logic [DROP_W-1:0]  dropped_frames;
    } fsr_result_t;

    typedef struct packed {
        logic [BYTES_W-1:0] bytes;
        logic [DIM_W-1:0]   width;
        logic [DIM_W-1:0]   height;
        logic [TIME_W-1:0]  stamp;
    } fsr_hdr_t;

    typedef struct packed {
        logic     en;
        idx_t     idx;
        fsr_hdr_t hdr;
    } fsr_hdr_wr_t;

    // positions run modulo 2*SLOT_COUNT so full and empty stay distinct
    function automatic pos_t pos_inc(input pos_t p);
        pos_t r;
        r = (p == pos_t'(POS_MOD - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    function automatic pos_t pos_dec(input pos_t p);
        pos_t r;
        r = (p == '0) ? pos_t'(POS_MOD - 1) : p - 1'b1;
        return r;
    endfunction

    function automatic idx_t pos_idx(input pos_t p);
        pos_t r;
        r = (p >= pos_t'(SLOT_COUNT)) ? p - pos_t'(SLOT_COUNT) : p;
        return idx_t'(r);
    endfunction

    function automatic pos_t pos_diff(input pos_t w, input pos_t r);
        pos_t d;
        d = (w >= r) ? w - r : w - r + pos_t'(POS_MOD);
        return d;
    endfunction

endpackage

FILE: hdl/fsr_req_if.sv
interface fsr_req_if;
    logic                                 valid;
    logic                                 ready;
    logic                                 kind;
    logic [fsr_pkg::BYTES_W-1:0]          in_bytes;
    logic [fsr_pkg::DIM_W-1:0]            in_width;
    logic [fsr_pkg::DIM_W-1:0]            in_height;
    logic [fsr_pkg::TIME_W-1:0]           in_time;
    logic [fsr_pkg::MODE_W-1:0]           read_mode;
    logic [fsr_pkg::BYTES_W-1:0]          buffer_limit;

    modport source (
        output valid, kind, in_bytes, in_width, in_height, in_time, read_mode, buffer_limit,
        input  ready
    );
    modport sink (
        input  valid, kind, in_bytes, in_width, in_height, in_time, read_mode, buffer_limit,
        output ready
    );
endinterface

FILE: hdl/fsr_rsp_if.sv
interface fsr_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [fsr_pkg::STAT_W-1:0]   status;
    logic [fsr_pkg::SLOT_W-1:0]   slot;
    logic [fsr_pkg::BYTES_W-1:0]  out_bytes;
    logic [fsr_pkg::DIM_W-1:0]    out_width;
    logic [fsr_pkg::DIM_W-1:0]    out_height;
    logic [fsr_pkg::TIME_W-1:0]   out_time;
    logic [fsr_pkg::SKIP_W-1:0]   skipped_frames;
    logic [fsr_pkg::DROP_W-1:0]   dropped_frames;

    modport source (
        output valid, status, slot, out_bytes, out_width, out_height, out_time,
               skipped_frames, dropped_frames,
        input  ready
    );
    modport sink (
        input  valid, status, slot, out_bytes, out_width, out_height, out_time,
               skipped_frames, dropped_frames,
        output ready
    );
endinterface

FILE: hdl/fsr_cfg_if.sv
interface fsr_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [fsr_pkg::CFG_IDX_W-1:0]     index;
    logic [fsr_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/fsr_hdr_store.sv
module fsr_hdr_store (
    input  logic                 clk,
    input  fsr_pkg::fsr_hdr_wr_t wr,
    input  fsr_pkg::idx_t        rd_idx,
    output fsr_pkg::fsr_hdr_t    rd_hdr
);

    // header per slot; contents are meaningless until the slot is written
    fsr_pkg::fsr_hdr_t mem_reg [fsr_pkg::SLOT_COUNT];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem_reg[wr.idx] <= wr.hdr;
        end
    end

    assign rd_hdr = mem_reg[rd_idx];

endmodule

FILE: hdl/fsr_ctrl.sv
module fsr_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  fsr_pkg::fsr_item_t              item,
    input  logic [fsr_pkg::BYTES_W-1:0]     slot_capacity,
    input  logic [fsr_pkg::TRIG_W-1:0]      clamp_trigger,
    output fsr_pkg::fsr_result_t            result
);

    fsr_pkg::pos_t              wpos_reg, wpos_next;
    fsr_pkg::pos_t              rpos_reg, rpos_next;
    logic [fsr_pkg::DROP_W-1:0] drop_reg, drop_next;

    fsr_pkg::pos_t     occ;
    fsr_pkg::pos_t     sel_pos;
    fsr_pkg::pos_t     skip_cnt;
    fsr_pkg::idx_t     rd_idx;
    fsr_pkg::idx_t     wr_idx;
    fsr_pkg::fsr_hdr_t rd_hdr;
    fsr_pkg::fsr_hdr_wr_t wr;
    logic              do_skip;

    assign occ    = fsr_pkg::pos_diff(wpos_reg, rpos_reg);
    assign wr_idx = fsr_pkg::pos_idx(wpos_reg);

    // clamped mode skips only when more than the trigger count is waiting
    assign do_skip = (item.read_mode == fsr_pkg::MODE_NEWEST) ||
                     ((item.read_mode == fsr_pkg::MODE_CLAMP) &&
                      (fsr_pkg::CMP_W'(occ) > fsr_pkg::CMP_W'(clamp_trigger)));
    assign sel_pos  = do_skip ? fsr_pkg::pos_dec(wpos_reg) : rpos_reg;
    assign skip_cnt = do_skip ? occ - 1'b1 : '0;
    assign rd_idx   = fsr_pkg::pos_idx(sel_pos);

    fsr_hdr_store u_store (
        .clk    (clk),
        .wr     (wr),
        .rd_idx (rd_idx),
        .rd_hdr (rd_hdr)
    );

    always_comb
    begin
        wpos_next = wpos_reg;
        rpos_next = rpos_reg;
        drop_next = drop_reg;
        result    = '0;
        wr.en     = 1'b0;
        wr.idx    = wr_idx;
        wr.hdr    = '{bytes: item.in_bytes, width: item.in_width,
                      height: item.in_height, stamp: item.in_time};

        if (item.kind == fsr_pkg::KIND_WRITE)
        begin
            if (item.in_bytes > slot_capacity)
            begin
                result.status = fsr_pkg::ST_LARGE;
            end
            else if (occ >= fsr_pkg::pos_t'(fsr_pkg::SLOT_COUNT))
            begin
                drop_next     = drop_reg + 1'b1;
                result.status = fsr_pkg::ST_FULL;
            end
            else
            begin
                wr.en         = fire;
                wpos_next     = fsr_pkg::pos_inc(wpos_reg);
                result.status = fsr_pkg::ST_OK;
                result.slot   = fsr_pkg::SLOT_W'(wr_idx);
            end
        end
        else
        begin
            if (occ == '0)
            begin
                result.status = fsr_pkg::ST_EMPTY;
            end
            else if (rd_hdr.bytes > item.buffer_limit)
            begin
                // refused: nothing committed, not even the skip
                result.status = fsr_pkg::ST_LARGE;
            end
            else
            begin
                rpos_next             = fsr_pkg::pos_inc(sel_pos);
                result.status         = fsr_pkg::ST_OK;
                result.slot           = fsr_pkg::SLOT_W'(rd_idx);
                result.out_bytes      = rd_hdr.bytes;
                result.out_width      = rd_hdr.width;
                result.out_height     = rd_hdr.height;
                result.out_time       = rd_hdr.stamp;
                result.skipped_frames = (skip_cnt > fsr_pkg::pos_t'(3)) ?
                                        fsr_pkg::SKIP_W'(3) :
                                        fsr_pkg::SKIP_W'(skip_cnt);
            end
        end
        result.dropped_frames = drop_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wpos_reg <= '0;
            rpos_reg <= '0;
            drop_reg <= '0;
        end
        else if (fire)
        begin
            wpos_reg <= wpos_next;
            rpos_reg <= rpos_next;
            drop_reg <= drop_next;
        end
    end

endmodule

FILE: hdl/frame_slot_ring_with_skip.sv
// Frame slot ring descriptor controller.
// req: one request per item. kind selects a header write (bytes, width, height,
//   time checked against slot_capacity and ring occupancy) or a frame read
//   (read_mode oldest / clamped skip / newest, checked against buffer_limit).
// rsp: exactly one result per request, in request order: status, slot index,
//   header of the frame read, frames skipped and the running drop count.
// cfg: register writes (0 slot_capacity, 1 clamp_trigger), always ready;
//   write only while no request is in flight.
// Pipeline: an accepted request is held in the input register, passes once
//   through the pointer and header logic, and is captured in the result
//   register when that is empty or rsp takes it. One request per cycle while
//   rsp takes results; ring pointers and drop counter update in that single
//   pass, so each request sees the state left by the one before it.
// Stall: when rsp is not taken the result register holds, the input register
//   still takes one more request, and req.ready drops after that.
// Reset (rst_n low, async): ring empty, drop count zero, registers at their
//   defaults, no result pending. Slot headers are not cleared; a slot is only
//   read after it was written.
module frame_slot_ring_with_skip (
    input  logic        clk,
    input  logic        rst_n,
    fsr_req_if.sink     req,
    fsr_rsp_if.source   rsp,
    fsr_cfg_if.sink     cfg
);

    logic [fsr_pkg::BYTES_W-1:0] cap_reg;
    logic [fsr_pkg::TRIG_W-1:0]  trig_reg;

    logic                 in_vld_reg, in_vld_next;
    fsr_pkg::fsr_item_t   in_reg;
    logic                 out_vld_reg, out_vld_next;
    fsr_pkg::fsr_result_t out_reg;
    fsr_pkg::fsr_result_t result;

    logic advance;
    logic req_take;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg  <= fsr_pkg::SLOT_CAPACITY_RST;
            trig_reg <= fsr_pkg::CLAMP_TRIGGER_RST;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == fsr_pkg::REG_SLOT_CAPACITY)
            begin
                cap_reg <= cfg.data;
            end
            else if (cfg.index == fsr_pkg::REG_CLAMP_TRIGGER)
            begin
                trig_reg <= cfg.data[fsr_pkg::TRIG_W-1:0];
            end
        end
    end

    assign advance   = in_vld_reg && (!out_vld_reg || rsp.ready);
    assign req.ready = !in_vld_reg || advance;
    assign req_take  = req.valid && req.ready;

    always_comb
    begin
        in_vld_next = in_vld_reg;
        if (req_take)
        begin
            in_vld_next = 1'b1;
        end
        else if (advance)
        begin
            in_vld_next = 1'b0;
        end

        out_vld_next = out_vld_reg;
        if (advance)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg  <= in_vld_next;
            out_vld_reg <= out_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_take)
        begin
            in_reg <= '{kind: req.kind, in_bytes: req.in_bytes, in_width: req.in_width,
                        in_height: req.in_height, in_time: req.in_time,
                        read_mode: req.read_mode, buffer_limit: req.buffer_limit};
        end
        if (advance)
        begin
            out_reg <= result;
        end
    end

    fsr_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .item          (in_reg),
        .slot_capacity (cap_reg),
        .clamp_trigger (trig_reg),
        .result        (result)
    );

    assign rsp.valid          = out_vld_reg;
    assign rsp.status         = out_reg.status;
    assign rsp.slot           = out_reg.slot;
    assign rsp.out_bytes      = out_reg.out_bytes;
    assign rsp.out_width      = out_reg.out_width;
    assign rsp.out_height     = out_reg.out_height;
    assign rsp.out_time       = out_reg.out_time;
    assign rsp.skipped_frames = out_reg.skipped_frames;
    assign rsp.dropped_frames = out_reg.dropped_frames;

endmodule
